// File: sv/swps_pkg.sv
`default_nettype none
package swps_pkg;

   // Set capacity and the widths derived from it
   localparam int MAX_VALIDATORS = 1024;
   localparam int POS_W          = $clog2(MAX_VALIDATORS + 1);
   localparam int SLOT_W         = $clog2(MAX_VALIDATORS);

   // Fixed field widths
   localparam int WORD_W    = 64;
   localparam int HALF_W    = 32;
   localparam int IDX_W     = 10;
   localparam int CSR_IDX_W = 2;

   // Hash finalizer constants
   localparam logic [WORD_W-1:0] FMIX_C1    = 64'hff51_afd7_ed55_8ccd;
   localparam logic [WORD_W-1:0] FMIX_C2    = 64'hc4ce_b9fe_1a85_ec53;
   localparam int                FMIX_SHIFT = 33;
   localparam logic [WORD_W-1:0] ALL_ONES   = {WORD_W{1'b1}};

   // Radix-2 divider: one quotient bit per cycle
   localparam int DIV_STEPS = WORD_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PREV_HASH    = 2'd0,
      CSR_ROUND_HEIGHT = 2'd1
   } csr_index_type;

   // Partial products of the 64x64 low-half multiply
   typedef enum logic [1:0] {
      MUL_LL = 2'd0,
      MUL_HL = 2'd1,
      MUL_LH = 2'd2
   } mul_step_type;

   typedef struct packed {
      logic         take;       // input side ready
      logic         load;       // beat accepted, capture it
      logic         mul_en;
      mul_step_type mul_step;
      logic         const_sel;  // 0: first constant, 1: second
      logic         fix;        // h = acc ^ (acc >> 33)
      logic         div_step;
      logic         update;     // compare against running best
   } dp_cmd_type;

   typedef struct packed {
      logic last;
      logic rsp_busy;
   } dp_status_type;

endpackage
`default_nettype wire

// File: sv/swps_if.sv
`default_nettype none
interface swps_req_if;
   logic                       valid;
   logic                       ready;
   logic [swps_pkg::WORD_W-1:0] key_word;
   logic                       active;
   logic [swps_pkg::WORD_W-1:0] stake;
   logic                       last_validator;

   modport source (output valid, key_word, active, stake, last_validator, input ready);
   modport sink   (input valid, key_word, active, stake, last_validator, output ready);
endinterface

interface swps_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic [swps_pkg::IDX_W-1:0]  winner_index;
   logic [swps_pkg::WORD_W-1:0] winner_score;
   logic                       overflow;

   modport source (output valid, found, winner_index, winner_score, overflow, input ready);
   modport sink   (input valid, found, winner_index, winner_score, overflow, output ready);
endinterface
`default_nettype wire

// File: sv/swps_ctrl.sv
`default_nettype none
module swps_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire swps_pkg::dp_status_type status,
   output swps_pkg::dp_cmd_type         cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MUL    = 5'b00010,
      ST_FIX    = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_UPDATE = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   logic [swps_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        round_ff, round_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      round_in = round_ff;
      cmd      = '0;
      cmd.mul_step  = swps_pkg::mul_step_type'(step_ff[1:0]);
      cmd.const_sel = round_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
               step_in  = '0;
               round_in = 1'b0;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            if (step_ff == swps_pkg::STEP_W'(swps_pkg::MUL_LH)) begin
               state_in = ST_FIX;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FIX: begin
            cmd.fix = 1'b1;
            step_in = '0;
            if (!round_ff) begin
               round_in = 1'b1;
               state_in = ST_MUL;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_ff == swps_pkg::STEP_W'(swps_pkg::DIV_STEPS - 1)) begin
               state_in = ST_UPDATE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            // on a last beat, hold off while a previous result is still pending
            if (!(status.last && status.rsp_busy)) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         round_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         round_ff <= round_in;
      end
   end

`ifndef SYNTH
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.update && status.last && status.rsp_busy))
      else $error("result overwritten while pending");

   a_load_starts_hash: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_MUL && step_ff == '0 && !round_ff))
      else $error("hash did not start after load");

   a_div_ends_in_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && step_ff == swps_pkg::STEP_W'(swps_pkg::DIV_STEPS - 1))
      |=> state_ff == ST_UPDATE)
      else $error("divide did not finish into update");

   a_mul_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> step_ff <= swps_pkg::STEP_W'(swps_pkg::MUL_LH))
      else $error("multiply step out of range");
`endif

endmodule
`default_nettype wire

// File: sv/swps_dp.sv
`default_nettype none
module swps_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [swps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [swps_pkg::WORD_W-1:0]       csr_wdata,
   input  wire logic [swps_pkg::WORD_W-1:0]       key_word,
   input  wire logic                              active,
   input  wire logic [swps_pkg::WORD_W-1:0]       stake,
   input  wire logic                              last_validator,
   input  wire swps_pkg::dp_cmd_type              cmd,
   output swps_pkg::dp_status_type                status,
   swps_rsp_if.source                             rsp
);

   localparam int W = swps_pkg::WORD_W;
   localparam int H = swps_pkg::HALF_W;

   logic [W-1:0] prev_hash_ff, round_height_ff;
   logic [W-1:0] h_ff, h_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] stake_ff;
   logic         excl_ff, last_ff;

   logic [W-1:0]                 best_score_ff, best_score_in;
   logic [swps_pkg::SLOT_W-1:0]  best_pos_ff, best_pos_in;
   logic                         best_valid_ff, best_valid_in;
   logic [swps_pkg::POS_W-1:0]   item_pos_ff, item_pos_in;
   logic                         overflow_ff, overflow_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff;
   logic [swps_pkg::IDX_W-1:0]   rsp_index_ff;
   logic [W-1:0]                 rsp_score_ff;
   logic                         rsp_overflow_ff;

   logic [W-1:0] mix0, fixed, mul_k;
   logic [H-1:0] op_a, op_b;
   logic [W-1:0] prod;
   logic [W:0]   trial;
   logic [W-1:0] score;
   logic         beyond;
   logic [swps_pkg::SLOT_W-1:0] slot;
   logic         better;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_hash_ff    <= '0;
         round_height_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            swps_pkg::CSR_PREV_HASH:    prev_hash_ff    <= csr_wdata;
            swps_pkg::CSR_ROUND_HEIGHT: round_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shared 32x32 multiplier over three partial products
   always_comb begin
      mix0  = key_word ^ prev_hash_ff ^ round_height_ff;
      mul_k = cmd.const_sel ? swps_pkg::FMIX_C2 : swps_pkg::FMIX_C1;
      op_a  = h_ff[H-1:0];
      op_b  = mul_k[H-1:0];
      case (cmd.mul_step)
         swps_pkg::MUL_HL: op_a = h_ff[W-1:H];
         swps_pkg::MUL_LH: op_b = mul_k[W-1:H];
         default: ;
      endcase
      prod  = W'(op_a) * W'(op_b);
      fixed = acc_ff ^ (acc_ff >> swps_pkg::FMIX_SHIFT);
      trial = {rem_ff, h_ff[W-1]} - {1'b0, stake_ff};
   end

   always_comb begin
      h_in   = h_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      if (cmd.load) begin
         h_in   = mix0 ^ (mix0 >> swps_pkg::FMIX_SHIFT);
         rem_in = '0;
      end
      if (cmd.mul_en) begin
         acc_in = (cmd.mul_step == swps_pkg::MUL_LL) ? prod
                                                     : acc_ff + {prod[H-1:0], {H{1'b0}}};
      end
      if (cmd.fix) begin
         h_in = fixed;
      end
      if (cmd.div_step) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            h_in   = {h_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], h_ff[W-1]};
            h_in   = {h_ff[W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      h_ff   <= h_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      if (cmd.load) begin
         stake_ff <= stake;
         excl_ff  <= !active || (stake == '0);
         last_ff  <= last_validator;
      end
   end

   // scoring, running minimum, result
   always_comb begin
      score  = excl_ff ? swps_pkg::ALL_ONES : ((h_ff == '0) ? W'(1) : h_ff);
      beyond = item_pos_ff >= swps_pkg::POS_W'(swps_pkg::MAX_VALIDATORS);
      slot   = beyond ? swps_pkg::SLOT_W'(swps_pkg::MAX_VALIDATORS - 1)
                      : item_pos_ff[swps_pkg::SLOT_W-1:0];
      better = score < best_score_ff;

      best_score_in = best_score_ff;
      best_pos_in   = best_pos_ff;
      best_valid_in = best_valid_ff;
      item_pos_in   = item_pos_ff;
      overflow_in   = overflow_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;

      if (cmd.update) begin
         overflow_in = overflow_ff || beyond;
         item_pos_in = beyond ? item_pos_ff : item_pos_ff + 1'b1;
         if (better) begin
            best_score_in = score;
            best_pos_in   = slot;
            best_valid_in = 1'b1;
         end
         if (last_ff) begin
            rsp_valid_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_score_ff <= swps_pkg::ALL_ONES;
         best_pos_ff   <= '0;
         best_valid_ff <= 1'b0;
         item_pos_ff   <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.update && last_ff) begin
            best_score_ff <= swps_pkg::ALL_ONES;
            best_pos_ff   <= '0;
            best_valid_ff <= 1'b0;
            item_pos_ff   <= '0;
            overflow_ff   <= 1'b0;
         end else begin
            best_score_ff <= best_score_in;
            best_pos_ff   <= best_pos_in;
            best_valid_ff <= best_valid_in;
            item_pos_ff   <= item_pos_in;
            overflow_ff   <= overflow_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && last_ff) begin
         rsp_found_ff    <= best_valid_in;
         rsp_index_ff    <= best_valid_in ? swps_pkg::IDX_W'(best_pos_in) : '0;
         rsp_score_ff    <= best_valid_in ? best_score_in : swps_pkg::ALL_ONES;
         rsp_overflow_ff <= overflow_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.found        = rsp_found_ff;
   assign rsp.winner_index = rsp_index_ff;
   assign rsp.winner_score = rsp_score_ff;
   assign rsp.overflow     = rsp_overflow_ff;

   assign status.last     = last_ff;
   assign status.rsp_busy = rsp_valid_ff && !rsp.ready;

endmodule
`default_nettype wire

// File: sv/stake_weighted_proposer_select.sv
// Stake-weighted proposer selection. Feed one validator per req beat (key word,
// active, stake, last marker); each is scored as fmix64(key ^ prev_hash ^ height)
// divided by stake (a zero quotient counts as 1; inactive or zero-stake scores
// all-ones), and the lowest score wins, earliest position on ties. The beat
// marked last produces one rsp beat (found, winner_index, winner_score,
// overflow) and starts a fresh set. One item occupies the block from accept to
// the next ready, so no new beat is taken until it is done: an accept step, the
// two hash multiplies (three 32x32 partial products each on a shared multiplier
// plus a mix step), the radix-2 divider (one quotient bit per cycle) and a
// compare/update step. A result sits in an output register; the next set
// keeps streaming in while it waits, and only the next last beat's update
// stalls until it is taken. Positions past capacity are clamped to the final
// slot and flag overflow. CSR writes (prev_hash_word at index 0, round_height
// at 1) must only happen while the block is idle.
`default_nettype none
module stake_weighted_proposer_select (
   input  wire logic                           clock,
   input  wire logic                           reset,
   swps_req_if.sink                            req,
   swps_rsp_if.source                          rsp,
   input  wire logic                           csr_wr_en,
   input  wire logic [swps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [swps_pkg::WORD_W-1:0]    csr_wdata
);

   swps_pkg::dp_cmd_type    cmd;
   swps_pkg::dp_status_type status;

   // sequencer: accept, hash, divide, update
   swps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // ready only while the sequencer waits for a beat
   assign req.ready = cmd.take;

   // hash, divider, running minimum and result register
   swps_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .key_word       (req.key_word),
      .active         (req.active),
      .stake          (req.stake),
      .last_validator (req.last_validator),
      .cmd            (cmd),
      .status         (status),
      .rsp            (rsp)
   );

endmodule
`default_nettype wire

// File: sim/stake_weighted_proposer_select_checker.sv
module stake_weighted_proposer_select_checker (
   input  logic                           clock,
   input  logic                           reset,
   swps_req_if                            req,
   swps_rsp_if                            rsp,
   input  logic                           csr_wr_en,
   input  logic [swps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [swps_pkg::WORD_W-1:0]    csr_wdata,
   output int unsigned                    failures,
   output int unsigned                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned                 SET_CAPACITY = 1024;
   localparam logic [swps_pkg::WORD_W-1:0] MIX_MUL_A    = 64'hff51_afd7_ed55_8ccd;
   localparam logic [swps_pkg::WORD_W-1:0] MIX_MUL_B    = 64'hc4ce_b9fe_1a85_ec53;
   localparam int                          MIX_SHIFT    = 33;
   localparam logic [swps_pkg::WORD_W-1:0] NO_SCORE     = {swps_pkg::WORD_W{1'b1}};

   typedef struct packed {
      logic                        found;
      logic [swps_pkg::IDX_W-1:0]  winner_index;
      logic [swps_pkg::WORD_W-1:0] winner_score;
      logic                        overflow;
   } selection_type;

   selection_type               selections_due[$];
   logic [swps_pkg::WORD_W-1:0] seed_hash;
   logic [swps_pkg::WORD_W-1:0] seed_height;
   logic [swps_pkg::WORD_W-1:0] lead_score;
   logic [swps_pkg::IDX_W-1:0]  lead_slot;
   logic                        lead_found;
   logic                        set_overflowed;
   int unsigned                 set_count;
   int unsigned                 error_count;

   function automatic logic [swps_pkg::WORD_W-1:0] finalize_hash(
         input logic [swps_pkg::WORD_W-1:0] h);
      h = h ^ (h >> MIX_SHIFT);
      h = h * MIX_MUL_A;
      h = h ^ (h >> MIX_SHIFT);
      h = h * MIX_MUL_B;
      h = h ^ (h >> MIX_SHIFT);
      return h;
   endfunction

   function automatic logic [swps_pkg::WORD_W-1:0] stake_score(
         input logic [swps_pkg::WORD_W-1:0] key,
         input logic                        act,
         input logic [swps_pkg::WORD_W-1:0] stk);
      logic [swps_pkg::WORD_W-1:0] q;
      if (!act || stk == '0)
         return NO_SCORE;
      q = finalize_hash(key ^ seed_hash ^ seed_height) / stk;
      return (q == '0) ? 64'd1 : q;
   endfunction

   function automatic void clear_set();
      lead_score     = NO_SCORE;
      lead_slot      = '0;
      lead_found     = 1'b0;
      set_count      = 0;
      set_overflowed = 1'b0;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t ns: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      selection_type               want;
      logic [swps_pkg::WORD_W-1:0] score;
      logic [swps_pkg::IDX_W-1:0]  slot;
      if (reset) begin
         seed_hash   = '0;
         seed_height = '0;
         clear_set();
         selections_due.delete();
         error_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               swps_pkg::CSR_PREV_HASH:    seed_hash = csr_wdata;
               swps_pkg::CSR_ROUND_HEIGHT: seed_height = csr_wdata;
               default: ;
            endcase
         end

         // result beat: compare against the oldest closed set
         if (rsp.valid && rsp.ready) begin
            if (selections_due.size() == 0) begin
               report_mismatch($sformatf("result beat with no set closed: found=%0b idx=%0d",
                                         rsp.found, rsp.winner_index));
            end else begin
               want = selections_due.pop_front();
               if (rsp.found !== want.found)
                  report_mismatch($sformatf("found got %0b want %0b",
                                            rsp.found, want.found));
               if (rsp.winner_index !== want.winner_index)
                  report_mismatch($sformatf("winner_index got %0d want %0d",
                                            rsp.winner_index, want.winner_index));
               if (rsp.winner_score !== want.winner_score)
                  report_mismatch($sformatf("winner_score got %h want %h",
                                            rsp.winner_score, want.winner_score));
               if (rsp.overflow !== want.overflow)
                  report_mismatch($sformatf("overflow got %0b want %0b",
                                            rsp.overflow, want.overflow));
            end
         end

         // validator beat: score it and update the running minimum
         if (req.valid && req.ready) begin
            if (set_count >= SET_CAPACITY) begin
               set_overflowed = 1'b1;
               slot = swps_pkg::IDX_W'(SET_CAPACITY - 1);
            end else begin
               slot = swps_pkg::IDX_W'(set_count);
               set_count++;
            end
            score = stake_score(req.key_word, req.active, req.stake);
            if (score < lead_score) begin
               lead_score = score;
               lead_slot  = slot;
               lead_found = 1'b1;
            end
            if (req.last_validator) begin
               want.found        = lead_found;
               want.winner_index = lead_found ? lead_slot : '0;
               want.winner_score = lead_found ? lead_score : NO_SCORE;
               want.overflow     = set_overflowed;
               selections_due.push_back(want);
               clear_set();
            end
         end
      end
      failures <= error_count;
      pending  <= selections_due.size();
   end

endmodule

// File: sim/stake_weighted_proposer_select_test.sv
module stake_weighted_proposer_select_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD      = 4;
   localparam int RESET_CYCLES    = 9;
   localparam int IDLE_PERCENT    = 15;
   // settle for longer than one validator occupies the block
   localparam int SETTLE_CYCLES   = 100;
   localparam int RSP_HOLD_CYCLES = 1500;
   // longest legal quiet spell is the result hold-off plus one item; 6x margin
   localparam int WATCHDOG_LIMIT  = 10000;
   localparam int PHASES          = 8;
   localparam int PHASE_ITEMS     = 64;
   localparam int STEADY_PHASE    = 3;
   localparam int PRESSURE_PHASE  = 5;
   localparam int OVERFLOW_PHASE  = 6;
   localparam int OVERFLOW_SET    = 1026;
   localparam int CAPACITY        = 1024;

   // register indexes past the list: writes there must be ignored
   localparam logic [swps_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [swps_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam logic [swps_pkg::WORD_W-1:0] ALL_SET  = {swps_pkg::WORD_W{1'b1}};
   localparam logic [swps_pkg::WORD_W-1:0] NONE_SET = '0;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_wr_en;
   logic [swps_pkg::CSR_IDX_W-1:0] csr_index;
   logic [swps_pkg::WORD_W-1:0]    csr_wdata;

   logic                 no_idle;       // both sides stream without gaps
   logic                 hold_request;  // ask the result side for one long hold-off
   int unsigned          failures;
   int unsigned          pending;
   int unsigned          quiet_cycles;

   swps_req_if req_ch();
   swps_rsp_if rsp_ch();

   stake_weighted_proposer_select uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   stake_weighted_proposer_select_checker checker_i (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Watchdog: ends the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL stake_weighted_proposer_select");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: random backpressure, plus one long hold-off on request so the
   // output register stays full and the block has to stall its input.
   initial begin
      bit held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
            @(posedge clock);
         end
      end
   end

   // Key words: mostly random, with the two extremes showing up now and then.
   function automatic logic [swps_pkg::WORD_W-1:0] pick_key();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 8)
         return NONE_SET;
      if (sel < 16)
         return ALL_SET;
      return {$urandom, $urandom};
   endfunction

   // Stakes spread over all magnitudes so quotients range from 0 (clamped to 1)
   // up to the full hash; zero stake excludes the validator.
   function automatic logic [swps_pkg::WORD_W-1:0] pick_stake();
      logic [swps_pkg::WORD_W-1:0] v;
      int unsigned                 sel;
      v   = {$urandom, $urandom};
      sel = $urandom_range(99);
      if (sel < 6)
         return NONE_SET;
      if (sel < 14)
         return 64'd1;
      if (sel < 20)
         return ALL_SET;
      if (sel < 50)
         return v >> $urandom_range(63);
      if (sel < 75)
         return v >> $urandom_range(63, 40);
      return v;
   endfunction

   // One validator beat. Called at a rising edge; returns at the edge where the
   // beat is taken. valid stays high across back-to-back beats.
   task automatic offer_validator(input logic [swps_pkg::WORD_W-1:0] key, input logic act,
                                  input logic [swps_pkg::WORD_W-1:0] stk,
                                  input logic last_flag);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.key_word       <= key;
      req_ch.active         <= act;
      req_ch.stake          <= stk;
      req_ch.last_validator <= last_flag;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // A well-formed set with random content; about one validator in ten repeats
   // its predecessor to force score ties.
   task automatic send_random_set(input int unsigned size);
      logic [swps_pkg::WORD_W-1:0] key;
      logic [swps_pkg::WORD_W-1:0] stk;
      logic [swps_pkg::WORD_W-1:0] prev_key;
      logic [swps_pkg::WORD_W-1:0] prev_stk;
      prev_key = pick_key();
      prev_stk = pick_stake();
      for (int unsigned i = 0; i < size; i++) begin
         if (i != 0 && $urandom_range(99) < 10) begin
            key = prev_key;
            stk = prev_stk;
         end else begin
            key = pick_key();
            stk = pick_stake();
         end
         offer_validator(key, $urandom_range(99) >= 12, stk, i == size - 1);
         prev_key = key;
         prev_stk = stk;
      end
   endtask

   task automatic write_csr(input logic [swps_pkg::CSR_IDX_W-1:0] idx,
                            input logic [swps_pkg::WORD_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Both registers, then junk into the unused indexes.
   task automatic configure(input logic [swps_pkg::WORD_W-1:0] hash_word,
                            input logic [swps_pkg::WORD_W-1:0] height);
      write_csr(swps_pkg::CSR_PREV_HASH, hash_word);
      write_csr(swps_pkg::CSR_ROUND_HEIGHT, height);
      write_csr(CSR_SPARE_2, {$urandom, $urandom});
      write_csr(CSR_SPARE_3, {$urandom, $urandom});
      csr_wr_en <= 1'b0;
   endtask

   // Wait until every closed set has been answered, then give the block time to
   // finish anything still in flight.
   task automatic settle();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [swps_pkg::WORD_W-1:0] hash_word;
      logic [swps_pkg::WORD_W-1:0] height;
      int unsigned                 phase_items;
      int unsigned                 size;
      int unsigned                 sel;

      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.key_word       <= '0;
      req_ch.active         <= 1'b0;
      req_ch.stake          <= '0;
      req_ch.last_validator <= 1'b0;
      csr_wr_en             <= 1'b0;
      csr_index             <= swps_pkg::CSR_PREV_HASH;
      csr_wdata             <= '0;
      no_idle               <= 1'b0;
      hold_request          <= 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed sets, zero seed ----
      configure(NONE_SET, NONE_SET);
      // set of one: hash of zero is zero, quotient clamps to 1
      offer_validator(NONE_SET, 1'b1, 64'd1, 1'b1);
      // set of one, excluded validator: nothing found
      offer_validator({$urandom, $urandom}, 1'b0, 64'd5, 1'b1);
      // excluded only: zero stake, inactive, zero stake again
      offer_validator({$urandom, $urandom}, 1'b1, NONE_SET, 1'b0);
      offer_validator({$urandom, $urandom}, 1'b0, 64'd1, 1'b0);
      offer_validator(ALL_SET, 1'b1, NONE_SET, 1'b1);
      // full stake: quotient clamps to 1 for both, tie keeps the first
      offer_validator(ALL_SET, 1'b1, ALL_SET, 1'b0);
      offer_validator(64'd1, 1'b1, ALL_SET, 1'b0);
      offer_validator({$urandom, $urandom}, 1'b1, 64'd1, 1'b0);
      offer_validator({$urandom, $urandom}, 1'b0, ALL_SET, 1'b1);
      // minimum in the middle, then an exact tie that must not move it
      offer_validator(ALL_SET, 1'b1, 64'd1, 1'b0);
      offer_validator(NONE_SET, 1'b1, 64'd1, 1'b0);
      offer_validator(NONE_SET, 1'b1, 64'd1, 1'b0);
      offer_validator(64'h8000_0000_0000_0000, 1'b1, 64'd2, 1'b1);
      // minimum on the last validator of the set
      offer_validator({$urandom, $urandom}, 1'b1, 64'd1, 1'b0);
      offer_validator({$urandom, $urandom}, 1'b1, 64'd3, 1'b0);
      offer_validator(NONE_SET, 1'b1, ALL_SET, 1'b1);
      req_ch.valid <= 1'b0;
      settle();

      // ---- random phases, each with its own seed setting ----
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               hash_word = ALL_SET;
               height    = ALL_SET;
            end
            1: begin
               hash_word = ALL_SET;
               height    = NONE_SET;
            end
            2: begin
               hash_word = NONE_SET;
               height    = ALL_SET;
            end
            4: begin
               hash_word = {$urandom, $urandom};
               height    = {32'd0, $urandom};  // realistic block height
            end
            default: begin
               hash_word = {$urandom, $urandom};
               height    = {$urandom, $urandom};
            end
         endcase
         configure(hash_word, height);
         no_idle <= (p == STEADY_PHASE);
         if (p == PRESSURE_PHASE)
            hold_request <= 1'b1;

         // Oversized set: positions up to capacity get small stakes and large
         // scores; beats past capacity take full stake, score 1, and land on the
         // saturated final slot with the overflow flag set.
         if (p == OVERFLOW_PHASE) begin
            for (int i = 0; i < OVERFLOW_SET; i++) begin
               if (i < CAPACITY)
                  offer_validator({$urandom, $urandom}, 1'b1,
                                  64'($urandom_range(65535, 1)), 1'b0);
               else
                  offer_validator({$urandom, $urandom}, 1'b1, ALL_SET,
                                  i == OVERFLOW_SET - 1);
            end
         end

         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 70)
               size = $urandom_range(4, 1);
            else if (sel < 95)
               size = $urandom_range(16, 5);
            else
               size = $urandom_range(48, 17);
            send_random_set(size);
            phase_items += size;
         end
         req_ch.valid <= 1'b0;
         settle();
      end

      if (failures == 0)
         $display("PASS stake_weighted_proposer_select");
      else
         $display("FAIL stake_weighted_proposer_select");
      $finish;
   end

endmodule

// File: sim.f
sv/swps_pkg.sv
sv/swps_if.sv
sv/swps_ctrl.sv
sv/swps_dp.sv
sv/stake_weighted_proposer_select.sv
sim/stake_weighted_proposer_select_checker.sv
sim/stake_weighted_proposer_select_test.sv
